@@ rtl/lcfr_pkg.sv @@
// Package for the length-prefixed frame receiver.
// Holds the phase and result kind codes and the result struct.
// No dependencies; every other file in rtl/ uses it.
package lcfr_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'h00;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] position;
    } result_t;

endpackage

@@ rtl/lcfr_if.sv @@
// Valid/ready channel interfaces for the frame receiver.
// Depends on lcfr_pkg for field widths.
interface lcfr_byte_if;
    logic                      valid;
    logic                      ready;
    logic [lcfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfr_result_if;
    logic                        valid;
    logic                        ready;
    logic [lcfr_pkg::KIND_W-1:0] kind;
    logic [lcfr_pkg::BYTE_W-1:0] data;
    logic [lcfr_pkg::BYTE_W-1:0] position;

    modport source (output valid, output kind, output data, output position, input ready);
    modport sink   (input valid, input kind, input data, input position, output ready);
endinterface

@@ rtl/lcfr_core.sv @@
// Frame parser: phase, length, count and checksum registers plus the
// per-byte result logic. Depends on lcfr_pkg.
module lcfr_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [lcfr_pkg::BYTE_W-1:0] rx_byte,
    output lcfr_pkg::result_t           result
);

    lcfr_pkg::phase_t            phase_reg, phase_next;
    logic [lcfr_pkg::BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic [lcfr_pkg::BYTE_W-1:0] byte_count_reg, byte_count_next;
    logic [lcfr_pkg::BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic                        is_idle;

    assign is_idle = (rx_byte == lcfr_pkg::IDLE_BYTE);

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        if (!is_idle)
        begin
            case (phase_reg)
                lcfr_pkg::PH_HUNT:
                begin
                    if (rx_byte == lcfr_pkg::SYNC_BYTE)
                        phase_next = lcfr_pkg::PH_LEN;
                end
                lcfr_pkg::PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    running_sum_next  = rx_byte;
                    byte_count_next   = '0;
                    phase_next        = lcfr_pkg::PH_DATA;
                end
                lcfr_pkg::PH_DATA:
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                    byte_count_next  = byte_count_reg + 8'd1;
                    if (byte_count_next == frame_length_reg)
                        phase_next = lcfr_pkg::PH_SUM;
                end
                lcfr_pkg::PH_SUM:
                begin
                    phase_next = lcfr_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = lcfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Result for the byte at the input
    always_comb
    begin
        result.valid    = 1'b0;
        result.kind     = lcfr_pkg::KIND_PAYLOAD;
        result.data     = rx_byte;
        result.position = byte_count_reg;
        if (!is_idle)
        begin
            case (phase_reg)
                lcfr_pkg::PH_DATA:
                begin
                    result.valid = 1'b1;
                end
                lcfr_pkg::PH_SUM:
                begin
                    result.valid    = 1'b1;
                    result.kind     = (rx_byte == running_sum_reg) ? lcfr_pkg::KIND_ACCEPT
                                                                   : lcfr_pkg::KIND_REJECT;
                    result.position = frame_length_reg;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lcfr_pkg::PH_HUNT;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
        end
    end

    // A payload phase always has bytes left to take
    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lcfr_pkg::PH_DATA |-> byte_count_reg < frame_length_reg)
        else $error("byte count reached frame length in payload phase");

    // A checksum byte ends the frame
    a_sum_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !is_idle && phase_reg == lcfr_pkg::PH_SUM)
        |=> phase_reg == lcfr_pkg::PH_HUNT)
        else $error("checksum byte did not return to hunting");

endmodule

@@ rtl/length_checksum_frame_receiver.sv @@
// Length-prefixed frame receiver with additive checksum.
// A result passes the input register and then the result register on its way out.
// Throughput: one byte per cycle; a byte with a result waits while the result register is held.
// Zero bytes and bytes outside a frame pass through the input register and yield no result.
// Reset (rst_n, async, active low) clears both valid flags and returns the parser to sync hunting.
// Depends on lcfr_pkg, lcfr_if and lcfr_core.
module length_checksum_frame_receiver (
    input  logic          clk,
    input  logic          rst_n,
    lcfr_byte_if.sink     byte_ch,
    lcfr_result_if.source result_ch
);

    logic                        in_valid_reg;
    logic [lcfr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    lcfr_pkg::kind_t             out_kind_reg;
    logic [lcfr_pkg::BYTE_W-1:0] out_data_reg;
    logic [lcfr_pkg::BYTE_W-1:0] out_position_reg;
    lcfr_pkg::result_t           result;
    logic                        advance;
    logic                        out_free;

    lcfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    assign out_free      = !out_valid_reg || result_ch.ready;
    // Hold the input byte only when it has a result and the output slot is taken
    assign advance       = in_valid_reg && (!result.valid || out_free);
    assign byte_ch.ready = !in_valid_reg || advance;

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.kind     = out_kind_reg;
    assign result_ch.data     = out_data_reg;
    assign result_ch.position = out_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
                in_valid_reg <= byte_ch.valid;
            if (advance && result.valid)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
            in_byte_reg <= byte_ch.rx_byte;
        if (advance && result.valid)
        begin
            out_kind_reg     <= result.kind;
            out_data_reg     <= result.data;
            out_position_reg <= result.position;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.valid) |-> (!out_valid_reg || result_ch.ready))
        else $error("result register overwritten before transaction");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !byte_ch.ready)
        else $error("input taken while input register is stalled");

endmodule

@@ tb/lcfr_frame_checker.sv @@
// Checker for the length-prefixed frame receiver: watches both channels,
// tracks the parser state and compares each result against the predicted one.
// Depends on lcfr_pkg and the channel interfaces in lcfr_if.
`timescale 1ns / 100ps

module lcfr_frame_checker
    import lcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcfr_byte_if          byte_ch,
    lcfr_result_if        result_ch,
    output int            mismatch_count,
    output int            pending_count
);

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] position;
    } frame_event_t;

    phase_t            parse_phase;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] payload_count;
    logic [BYTE_W-1:0] checksum_acc;

    frame_event_t      expected_events[$];

    // Advance the parser by one received byte; returns 1 when the byte yields a result.
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output frame_event_t ev);
        ev = '0;
        if (b == IDLE_BYTE)
            return 1'b0;
        case (parse_phase)
            PH_HUNT:
            begin
                if (b == SYNC_BYTE)
                    parse_phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN:
            begin
                frame_len     = b;
                checksum_acc  = b;
                payload_count = '0;
                parse_phase   = PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                ev.kind       = KIND_PAYLOAD;
                ev.data       = b;
                ev.position   = payload_count;
                checksum_acc  = checksum_acc + b;
                payload_count = payload_count + 1'b1;
                if (payload_count == frame_len)
                    parse_phase = PH_SUM;
                return 1'b1;
            end
            default:
            begin
                ev.kind     = (b == checksum_acc) ? KIND_ACCEPT : KIND_REJECT;
                ev.data     = b;
                ev.position = frame_len;
                parse_phase = PH_HUNT;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_event_t expected_evt;
        if (!rst_n)
        begin
            parse_phase    = PH_HUNT;
            frame_len      = '0;
            payload_count  = '0;
            checksum_acc   = '0;
            mismatch_count = 0;
            expected_events.delete();
        end
        else
        begin
            // Handle the byte first: a result on this edge always belongs to an older byte.
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (parse_rx_byte(byte_ch.rx_byte, expected_evt))
                    expected_events = {expected_events, expected_evt};
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected result: kind %0d data 0x%02h position %0d",
                           result_ch.kind, result_ch.data, result_ch.position);
                    mismatch_count++;
                end
                else
                begin
                    expected_evt = expected_events.pop_front();
                    if (result_ch.kind !== expected_evt.kind)
                    begin
                        $error("kind: expected %0d, actual %0d",
                               expected_evt.kind, result_ch.kind);
                        mismatch_count++;
                    end
                    if (result_ch.data !== expected_evt.data)
                    begin
                        $error("data: expected 0x%02h, actual 0x%02h",
                               expected_evt.data, result_ch.data);
                        mismatch_count++;
                    end
                    if (result_ch.position !== expected_evt.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               expected_evt.position, result_ch.position);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_events.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the frame receiver testbench: clock, reset, byte stimulus and result backpressure.
// Instantiates length_checksum_frame_receiver and lcfr_frame_checker side by side.
// Depends on lcfr_pkg, lcfr_if and the checker.
`timescale 1ns / 100ps

module tb_top;
    import lcfr_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 48;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 100;

    logic clk = 1'b0;
    logic rst_n;

    lcfr_byte_if   byte_ch();
    lcfr_result_if result_ch();

    int  mismatch_count;
    int  pending_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  bytes_sent;
    int  hold_requests;
    int  hold_served = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    logic byte_taken;

    length_checksum_frame_receiver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    lcfr_frame_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_ch        (byte_ch),
        .result_ch      (result_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Capture acceptance at the edge so the sender can act on it at the next falling edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_taken <= 1'b0;
        else
            byte_taken <= byte_ch.valid && byte_ch.ready;
    end

    // Receiver: random stalls, plus a long hold-off each time one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready = 1'b0;
        else if (hold_left > 0)
        begin
            result_ch.ready = 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            result_ch.ready = 1'b0;
        end
        else
            result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid   = 1'b0;
            byte_ch.rx_byte = BYTE_W'($urandom);
            @(negedge clk);
        end
        byte_ch.valid   = 1'b1;
        byte_ch.rx_byte = b;
        @(negedge clk);
        while (!byte_taken)
            @(negedge clk);
        if (b != IDLE_BYTE)
            bytes_sent++;
    endtask

    // Slip in an idle byte now and then; the parser must skip it in any phase.
    task automatic send_stray_idle();
        if ($urandom_range(9) == 0)
            send_byte(IDLE_BYTE);
    endtask

    task automatic send_frame(input int len, input bit corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] chk;
        send_byte(SYNC_BYTE);
        send_stray_idle();
        send_byte(BYTE_W'(len));
        sum = BYTE_W'(len);
        for (int i = 0; i < len; i++)
        begin
            send_stray_idle();
            b = BYTE_W'($urandom_range(1, 255));
            send_byte(b);
            sum = sum + b;
        end
        send_stray_idle();
        chk = sum;
        // A zero checksum cannot be sent, so such a frame always goes out with a wrong one.
        while (chk == IDLE_BYTE || (corrupt && chk == sum))
            chk = BYTE_W'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    task automatic run_random(input int count);
        int start;
        int roll;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                len = ($urandom_range(99) < 2) ? $urandom_range(128, 255) : $urandom_range(1, 8);
                send_frame(len, $urandom_range(3) == 0);
            end
            else if (roll < 85)
            begin
                // Line noise: mostly drops while hunting, may open a frame on 0xFF.
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom));
            end
            else
            begin
                // Truncated frame; whatever follows is parsed as its continuation.
                len = $urandom_range(2, 8);
                send_byte(SYNC_BYTE);
                send_byte(BYTE_W'(len));
                repeat ($urandom_range(0, len - 1))
                    send_byte(BYTE_W'($urandom_range(1, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.rx_byte   = IDLE_BYTE;
        result_ch.ready   = 1'b0;
        send_idle_pct     = 33;
        recv_idle_pct     = 57;
        bytes_sent        = 0;
        hold_requests     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hunting: idle and non-sync bytes drop.
        send_byte(IDLE_BYTE);
        send_byte(8'h12);
        send_byte(8'h80);
        send_byte(8'h7F);
        // Zero length and zero payload bytes skipped; frame accepted.
        send_byte(SYNC_BYTE);
        send_byte(IDLE_BYTE);
        send_byte(8'h01);
        send_byte(IDLE_BYTE);
        send_byte(8'hAA);
        send_byte(8'hAB);
        // Sync value as payload; checksum wraps, wrong one rejected.
        send_byte(SYNC_BYTE);
        send_byte(8'h02);
        send_byte(SYNC_BYTE);
        send_byte(8'h01);
        send_byte(8'h03);
        // Sync value as the checksum; accepted.
        send_byte(SYNC_BYTE);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(SYNC_BYTE);
        // True checksum zero: the idle byte is skipped, next byte taken as checksum.
        send_byte(SYNC_BYTE);
        send_byte(8'h01);
        send_byte(SYNC_BYTE);
        send_byte(IDLE_BYTE);
        send_byte(8'h55);

        run_random(RANDOM_ITEMS);

        send_idle_pct = 57;
        recv_idle_pct = 33;
        run_random(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Keep offering frames while results are held off, so the input stalls.
        hold_requests++;
        send_frame(8, 1'b0);
        send_frame(8, 1'b1);
        send_frame(255, 1'b0);
        run_random(RANDOM_ITEMS);

        byte_ch.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
